// File: src/llra_pkg.sv
// shared types and constants of the least-loaded rod assigner
package llra_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int LOAD_W        = 24;
  localparam int RANK_W        = 16;
  localparam int NODE_W        = 6;
  localparam int CFG_W         = 7;
  localparam int LEN_W         = 16;

  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};
  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

  // register index on the configuration port
  localparam logic REG_ACTIVE_NODES = 1'b0;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_PLACE  = 2'd1,
    ACT_REPORT = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [LOAD_W-1:0] load;
    logic [RANK_W-1:0] rods;
  } node_t;

  typedef struct packed {
    logic              lt;
    logic              gt;
    logic [LOAD_W-1:0] load_sum;
    logic [RANK_W-1:0] rods_inc;
  } cmp_res_t;

  typedef struct packed {
    logic [NODE_W-1:0] chosen_node;
    logic [RANK_W-1:0] rank_on_node;
    logic [LOAD_W-1:0] new_load;
    logic [LOAD_W-1:0] largest_load;
    logic [LOAD_W-1:0] smallest_load;
    logic [NODE_W-1:0] origin_node;
    logic [RANK_W-1:0] origin_rank;
    logic              origin_placed;
  } result_t;

endpackage

// File: src/llra_node_mem.sv
// per-node load and rod count memory, one write and one registered read port
module llra_node_mem #(
  parameter int Depth = llra_pkg::MAX_NODES_DEF,
  parameter int AddrW = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  llra_pkg::node_t     wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output llra_pkg::node_t     rdata_o
);

  llra_pkg::node_t mem [Depth];
  llra_pkg::node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/llra_cmp.sv
// shared compare and saturating update unit
module llra_cmp (
  input  llra_pkg::node_t                    node_i,
  input  logic [llra_pkg::LOAD_W-1:0]        lo_i,
  input  logic [llra_pkg::LOAD_W-1:0]        hi_i,
  input  logic [llra_pkg::LEN_W-1:0]         len_i,
  output llra_pkg::cmp_res_t                 res_o
);

  logic [llra_pkg::LOAD_W:0] sum;

  always_comb begin
    sum = {1'b0, node_i.load} + (llra_pkg::LOAD_W+1)'(len_i);
    res_o.lt = node_i.load < lo_i;
    res_o.gt = node_i.load > hi_i;
    res_o.load_sum = sum[llra_pkg::LOAD_W] ? llra_pkg::LOAD_MAX
                                           : sum[llra_pkg::LOAD_W-1:0];
    res_o.rods_inc = (node_i.rods == llra_pkg::RANK_MAX) ? node_i.rods
                                                         : node_i.rods + 1'b1;
  end

endmodule

// File: src/llra_seq.sv
// sequencer: scans the node memory through the shared compare unit
module llra_seq #(
  parameter int MaxNodes = llra_pkg::MAX_NODES_DEF,
  parameter int NodeW    = 6,
  parameter int CntW     = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0]                    action_i,
  input  logic [llra_pkg::LEN_W-1:0]    rod_length_i,
  input  logic                          rod_is_origin_i,
  input  logic [CntW-1:0]               node_count_i,
  output logic                          busy_o,
  output logic                          mem_we_o,
  output logic [NodeW-1:0]              mem_waddr_o,
  output llra_pkg::node_t               mem_wdata_o,
  output logic                          mem_re_o,
  output logic [NodeW-1:0]              mem_raddr_o,
  input  llra_pkg::node_t               mem_rdata_i,
  output llra_pkg::node_t               cmp_node_o,
  output logic [llra_pkg::LOAD_W-1:0]   cmp_lo_o,
  output logic [llra_pkg::LOAD_W-1:0]   cmp_hi_o,
  output logic [llra_pkg::LEN_W-1:0]    cmp_len_o,
  input  llra_pkg::cmp_res_t            cmp_res_i,
  output logic                          res_valid_o,
  output llra_pkg::result_t             res_o
);

  llra_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx;
  logic [1:0] act_q, act_d;
  logic [llra_pkg::LEN_W-1:0] len_q, len_d;
  logic orig_q, orig_d;
  llra_pkg::node_t lo_q, lo_d;
  logic [NodeW-1:0] best_q, best_d;
  logic [llra_pkg::LOAD_W-1:0] hi_q, hi_d;
  logic [llra_pkg::NODE_W-1:0] onode_q, onode_d;
  logic [llra_pkg::RANK_W-1:0] orank_q, orank_d;
  logic oseen_q, oseen_d;
  logic valid_q, valid_d;
  llra_pkg::result_t res_q, res_d;

  localparam logic [CntW-1:0] LastIdx = CntW'(MaxNodes - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= llra_pkg::ST_INIT;
      cnt_q   <= '0;
      onode_q <= '0;
      orank_q <= '0;
      oseen_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      onode_q <= onode_d;
      orank_q <= orank_d;
      oseen_q <= oseen_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    len_q  <= len_d;
    orig_q <= orig_d;
    lo_q   <= lo_d;
    best_q <= best_d;
    hi_q   <= hi_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    act_d   = act_q;
    len_d   = len_q;
    orig_d  = orig_q;
    lo_d    = lo_q;
    best_d  = best_q;
    hi_d    = hi_q;
    onode_d = onode_q;
    orank_d = orank_q;
    oseen_d = oseen_q;
    valid_d = 1'b0;
    res_d   = res_q;
    idx     = cnt_q - 1'b1;

    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q[NodeW-1:0];
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = cnt_q[NodeW-1:0];

    // scan compares read data, the final write uses the chosen node
    cmp_node_o = (state_q == llra_pkg::ST_FIN) ? lo_q : mem_rdata_i;
    cmp_lo_o   = lo_q.load;
    cmp_hi_o   = hi_q;
    cmp_len_o  = len_q;

    case (state_q)
      llra_pkg::ST_INIT, llra_pkg::ST_CLEAR: begin
        mem_we_o = 1'b1;
        onode_d  = '0;
        orank_d  = '0;
        oseen_d  = 1'b0;
        if (cnt_q == LastIdx) begin
          state_d = llra_pkg::ST_IDLE;
          cnt_d   = '0;
          if (state_q == llra_pkg::ST_CLEAR) begin
            valid_d = 1'b1;
            res_d   = '0;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      llra_pkg::ST_IDLE: begin
        if (start_i) begin
          act_d  = action_i;
          len_d  = rod_length_i;
          orig_d = rod_is_origin_i;
          case (llra_pkg::action_e'(action_i))
            llra_pkg::ACT_PLACE, llra_pkg::ACT_REPORT: begin
              mem_re_o    = 1'b1;
              mem_raddr_o = '0;
              cnt_d       = CntW'(1);
              state_d     = llra_pkg::ST_SCAN;
            end
            llra_pkg::ACT_CLEAR: begin
              cnt_d   = '0;
              state_d = llra_pkg::ST_CLEAR;
            end
            default: state_d = llra_pkg::ST_FIN;
          endcase
        end
      end
      llra_pkg::ST_SCAN: begin
        // read data belongs to node cnt_q-1
        if (cnt_q == CntW'(1)) begin
          lo_d   = mem_rdata_i;
          hi_d   = mem_rdata_i.load;
          best_d = '0;
        end else begin
          if (cmp_res_i.lt) begin
            lo_d   = mem_rdata_i;
            best_d = idx[NodeW-1:0];
          end
          if (cmp_res_i.gt) begin
            hi_d = mem_rdata_i.load;
          end
        end
        if (cnt_q < node_count_i) begin
          mem_re_o = 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end else begin
          state_d = llra_pkg::ST_FIN;
        end
      end
      llra_pkg::ST_FIN: begin
        valid_d = 1'b1;
        res_d   = '0;
        state_d = llra_pkg::ST_IDLE;
        case (llra_pkg::action_e'(act_q))
          llra_pkg::ACT_PLACE: begin
            mem_we_o         = 1'b1;
            mem_waddr_o      = best_q;
            mem_wdata_o.load = cmp_res_i.load_sum;
            mem_wdata_o.rods = cmp_res_i.rods_inc;
            res_d.chosen_node  = llra_pkg::NODE_W'(best_q);
            res_d.rank_on_node = lo_q.rods;
            res_d.new_load     = cmp_res_i.load_sum;
            if (orig_q) begin
              onode_d = llra_pkg::NODE_W'(best_q);
              orank_d = lo_q.rods;
              oseen_d = 1'b1;
            end
          end
          llra_pkg::ACT_REPORT: begin
            res_d.largest_load  = hi_q;
            res_d.smallest_load = lo_q.load;
            res_d.origin_node   = onode_q;
            res_d.origin_rank   = orank_q;
            res_d.origin_placed = oseen_q;
          end
          default: ;
        endcase
      end
      default: state_d = llra_pkg::ST_IDLE;
    endcase
  end

  assign busy_o      = (state_q != llra_pkg::ST_IDLE);
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: src/least_loaded_rod_assigner.sv
// top level: configuration port, node memory, compare unit and sequencer
//
// usage: drive action_i, rod_length_i and rod_is_origin_i and raise start while
// busy is low; the item is taken at that clock edge and busy rises.
// action clear zeroes every node and the origin record, place puts one rod on
// the active node with the smallest load (lowest id on a tie), report returns
// the largest and smallest load over the active nodes and the origin record.
// every item gives exactly one result, held on the result ports for one cycle
// with result_valid_o high; the receiver has no way to stall it.
// timing: place and report read one node per cycle from the node memory through
// a single compare unit, and the result shows in the first cycle with busy
// low; clear writes one node per cycle; an unused action code reads and
// writes no node.
// a new item may be started in the cycle that carries the previous result.
// after reset a clearing pass runs over the memory with busy high; configuration
// writes are taken at any time.
// active_nodes lives at byte address 0 of the apb port, reset value 1.
module least_loaded_rod_assigner #(
  parameter int MAX_NODES = llra_pkg::MAX_NODES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        action_i,
  input  logic [llra_pkg::LEN_W-1:0]        rod_length_i,
  input  logic                              rod_is_origin_i,
  output logic                              result_valid_o,
  output logic [llra_pkg::NODE_W-1:0]       chosen_node_o,
  output logic [llra_pkg::RANK_W-1:0]       rank_on_node_o,
  output logic [llra_pkg::LOAD_W-1:0]       new_load_o,
  output logic [llra_pkg::LOAD_W-1:0]       largest_load_o,
  output logic [llra_pkg::LOAD_W-1:0]       smallest_load_o,
  output logic [llra_pkg::NODE_W-1:0]       origin_node_o,
  output logic [llra_pkg::RANK_W-1:0]       origin_rank_o,
  output logic                              origin_placed_o
);

  localparam int NodeW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CntW  = $clog2(MAX_NODES + 1);

  logic [llra_pkg::CFG_W-1:0] active_q;
  logic [31:0] act32;
  logic [31:0] cnt32;
  logic [CntW-1:0] node_count;

  logic mem_we, mem_re;
  logic [NodeW-1:0] mem_waddr, mem_raddr;
  llra_pkg::node_t mem_wdata, mem_rdata;
  llra_pkg::node_t cmp_node;
  logic [llra_pkg::LOAD_W-1:0] cmp_lo, cmp_hi;
  logic [llra_pkg::LEN_W-1:0] cmp_len;
  llra_pkg::cmp_res_t cmp_res;
  llra_pkg::result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= llra_pkg::CFG_W'(1);
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == llra_pkg::REG_ACTIVE_NODES) begin
      active_q <= pwdata[llra_pkg::CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == llra_pkg::REG_ACTIVE_NODES) ? 32'(active_q) : '0;

  // zero acts as one, above the node count acts as the node count
  always_comb begin
    act32 = 32'(active_q);
    if (act32 == 32'd0) begin
      cnt32 = 32'd1;
    end else if (act32 > 32'(MAX_NODES)) begin
      cnt32 = 32'(MAX_NODES);
    end else begin
      cnt32 = act32;
    end
    node_count = cnt32[CntW-1:0];
  end

  llra_node_mem #(
    .Depth (MAX_NODES),
    .AddrW (NodeW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  llra_cmp u_cmp (
    .node_i (cmp_node),
    .lo_i   (cmp_lo),
    .hi_i   (cmp_hi),
    .len_i  (cmp_len),
    .res_o  (cmp_res)
  );

  llra_seq #(
    .MaxNodes (MAX_NODES),
    .NodeW    (NodeW),
    .CntW     (CntW)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .action_i        (action_i),
    .rod_length_i    (rod_length_i),
    .rod_is_origin_i (rod_is_origin_i),
    .node_count_i    (node_count),
    .busy_o          (busy),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata),
    .cmp_node_o      (cmp_node),
    .cmp_lo_o        (cmp_lo),
    .cmp_hi_o        (cmp_hi),
    .cmp_len_o       (cmp_len),
    .cmp_res_i       (cmp_res),
    .res_valid_o     (result_valid_o),
    .res_o           (res)
  );

  assign chosen_node_o   = res.chosen_node;
  assign rank_on_node_o  = res.rank_on_node;
  assign new_load_o      = res.new_load;
  assign largest_load_o  = res.largest_load;
  assign smallest_load_o = res.smallest_load;
  assign origin_node_o   = res.origin_node;
  assign origin_rank_o   = res.origin_rank;
  assign origin_placed_o = res.origin_placed;

endmodule

// File: sim/testbench.sv
// testbench for the least-loaded rod assigner: directed and random items against a predictor
`timescale 1ns / 1ps

module testbench;
  import llra_pkg::*;

  localparam logic [1:0]  ACT_UNUSED        = 2'd3;
  localparam logic [2:0]  ACTIVE_NODES_ADDR = 3'(4 * REG_ACTIVE_NODES);
  localparam int unsigned STALL_LIMIT       = 1000;
  localparam int unsigned RANDOM_PHASES     = 12;
  localparam int unsigned ITEMS_PER_PHASE   = 87;
  localparam int unsigned SAT_ITEMS         = 260;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              start;
  logic              busy;
  logic [1:0]        action_i;
  logic [LEN_W-1:0]  rod_length_i;
  logic              rod_is_origin_i;
  logic              result_valid_o;
  logic [NODE_W-1:0] chosen_node_o;
  logic [RANK_W-1:0] rank_on_node_o;
  logic [LOAD_W-1:0] new_load_o;
  logic [LOAD_W-1:0] largest_load_o;
  logic [LOAD_W-1:0] smallest_load_o;
  logic [NODE_W-1:0] origin_node_o;
  logic [RANK_W-1:0] origin_rank_o;
  logic              origin_placed_o;

  least_loaded_rod_assigner dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .rod_length_i    (rod_length_i),
    .rod_is_origin_i (rod_is_origin_i),
    .result_valid_o  (result_valid_o),
    .chosen_node_o   (chosen_node_o),
    .rank_on_node_o  (rank_on_node_o),
    .new_load_o      (new_load_o),
    .largest_load_o  (largest_load_o),
    .smallest_load_o (smallest_load_o),
    .origin_node_o   (origin_node_o),
    .origin_rank_o   (origin_rank_o),
    .origin_placed_o (origin_placed_o)
  );

  // predicted state of the node table
  logic [LOAD_W-1:0] node_load [MAX_NODES_DEF];
  logic [RANK_W-1:0] node_rods [MAX_NODES_DEF];
  logic [NODE_W-1:0] origin_node_q;
  logic [RANK_W-1:0] origin_rank_q;
  logic              origin_seen_q;
  logic [CFG_W-1:0]  active_cfg;

  result_t     outcome_q [$];
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned settings_tried;
  bit          no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void empty_all_nodes();
    for (int i = 0; i < MAX_NODES_DEF; i++) begin
      node_load[i] = '0;
      node_rods[i] = '0;
    end
    origin_node_q = '0;
    origin_rank_q = '0;
    origin_seen_q = 1'b0;
  endfunction

  // applies one item to the predicted node table and returns what the block should say
  function automatic result_t apply_action(logic [1:0] act, logic [LEN_W-1:0] len,
                                           logic origin);
    result_t           r;
    int                n;
    int                best;
    logic [LOAD_W:0]   sum;
    logic [LOAD_W-1:0] hi;
    logic [LOAD_W-1:0] lo;
    r = '0;
    if (active_cfg == 0) n = 1;
    else if (active_cfg > MAX_NODES_DEF) n = MAX_NODES_DEF;
    else n = int'(active_cfg);
    case (act)
      ACT_CLEAR: begin
        empty_all_nodes();
      end
      ACT_PLACE: begin
        best = 0;
        for (int i = 1; i < n; i++) begin
          if (node_load[i] < node_load[best]) best = i;
        end
        r.chosen_node  = NODE_W'(best);
        r.rank_on_node = node_rods[best];
        if (node_rods[best] != RANK_MAX) node_rods[best] = node_rods[best] + 1'b1;
        sum = {1'b0, node_load[best]} + len;
        node_load[best] = (sum > LOAD_MAX) ? LOAD_MAX : sum[LOAD_W-1:0];
        r.new_load = node_load[best];
        if (origin) begin
          origin_node_q = NODE_W'(best);
          origin_rank_q = r.rank_on_node;
          origin_seen_q = 1'b1;
        end
      end
      ACT_REPORT: begin
        hi = node_load[0];
        lo = node_load[0];
        for (int i = 1; i < n; i++) begin
          if (node_load[i] > hi) hi = node_load[i];
          if (node_load[i] < lo) lo = node_load[i];
        end
        r.largest_load  = hi;
        r.smallest_load = lo;
        r.origin_node   = origin_node_q;
        r.origin_rank   = origin_rank_q;
        r.origin_placed = origin_seen_q;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    error_count++;
    if (error_count <= 40) begin
      $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) report_mismatch(what, want, got);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result with no item outstanding", 0, 1);
      end else begin
        want = outcome_q.pop_front();
        check_field("chosen_node", want.chosen_node, chosen_node_o);
        check_field("rank_on_node", want.rank_on_node, rank_on_node_o);
        check_field("new_load", want.new_load, new_load_o);
        check_field("largest_load", want.largest_load, largest_load_o);
        check_field("smallest_load", want.smallest_load, smallest_load_o);
        check_field("origin_node", want.origin_node, origin_node_o);
        check_field("origin_rank", want.origin_rank, origin_rank_o);
        check_field("origin_placed", want.origin_placed, origin_placed_o);
        results_checked++;
      end
    end
  end

  // ends the run when neither an item nor a result moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || result_valid_o) quiet = 0;
      else quiet++;
    end
    $display("stalled for %0d cycles", STALL_LIMIT);
    $display("least_loaded_rod_assigner: mismatch");
    $finish;
  end

  task automatic send_item(logic [1:0] act, logic [LEN_W-1:0] len, logic origin);
    result_t expected;
    @(negedge clk_i);
    start           <= 1'b1;
    action_i        <= act;
    rod_length_i    <= len;
    rod_is_origin_i <= origin;
    do @(posedge clk_i); while (busy);
    expected  = apply_action(act, len, origin);
    outcome_q = {outcome_q, expected};
    items_sent++;
  endtask

  task automatic idle_gap(int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      start           <= 1'b0;
      action_i        <= 2'($urandom);
      rod_length_i    <= LEN_W'($urandom);
      rod_is_origin_i <= 1'($urandom);
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [1:0] pick_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return ACT_PLACE;
    if (r < 93) return ACT_REPORT;
    if (r < 97) return ACT_CLEAR;
    return ACT_UNUSED;
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return LEN_W'($urandom);
    if (r < 75) return LEN_W'($urandom_range(0, 15));
    if (r < 85) return '1;
    if (r < 95) return LEN_W'($urandom_range(65500, 65535));
    return '0;
  endfunction

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  // waits for the block to go quiet, writes active_nodes and reads it back
  task automatic set_active_nodes(logic [CFG_W-1:0] value);
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ACTIVE_NODES_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    active_cfg = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    psel    <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("active_nodes read back", active_cfg, prdata[CFG_W-1:0]);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_tried++;
  endtask

  task automatic test_reset_state();
    send_item(ACT_REPORT, '0, 1'b0);
    send_item(ACT_PLACE, 16'd5, 1'b0);
    send_item(ACT_REPORT, '1, 1'b1);
  endtask

  task automatic test_directed_basics();
    set_active_nodes(7'd4);
    send_item(ACT_REPORT, '0, 1'b0);
    // equal loads on nodes 1..3 go to the lowest id
    send_item(ACT_PLACE, 16'd100, 1'b0);
    send_item(ACT_PLACE, 16'd100, 1'b0);
    send_item(ACT_PLACE, '0, 1'b1);
    send_item(ACT_PLACE, '0, 1'b0);
    send_item(ACT_PLACE, '1, 1'b0);
    send_item(ACT_PLACE, '1, 1'b1);
    send_item(ACT_REPORT, '0, 1'b0);
    send_item(ACT_UNUSED, '1, 1'b1);
    send_item(ACT_REPORT, 16'h5a5a, 1'b0);
    send_item(ACT_CLEAR, 16'ha5a5, 1'b1);
    send_item(ACT_REPORT, '0, 1'b0);
    send_item(ACT_PLACE, '1, 1'b1);
    send_item(ACT_PLACE, 16'd1, 1'b0);
    send_item(ACT_REPORT, '0, 1'b0);
  endtask

  task automatic test_active_range();
    // zero acts as one node, anything above the node count as all nodes
    set_active_nodes(7'd0);
    send_item(ACT_PLACE, 16'd7, 1'b0);
    send_item(ACT_PLACE, 16'd9, 1'b0);
    send_item(ACT_REPORT, '0, 1'b0);
    set_active_nodes(7'd127);
    send_item(ACT_PLACE, '1, 1'b1);
    send_item(ACT_PLACE, 16'd3, 1'b0);
    send_item(ACT_REPORT, '0, 1'b0);
    set_active_nodes(7'd64);
    send_item(ACT_REPORT, '0, 1'b0);
    // nodes dropped from the active range keep their load
    set_active_nodes(7'd8);
    for (int i = 0; i < 8; i++) send_item(ACT_PLACE, LEN_W'(1000 * (i + 1)), 1'b0);
    set_active_nodes(7'd2);
    send_item(ACT_REPORT, '0, 1'b0);
    send_item(ACT_PLACE, 16'd1, 1'b0);
    set_active_nodes(7'd8);
    send_item(ACT_REPORT, '0, 1'b0);
  endtask

  task automatic test_saturation();
    set_active_nodes(7'd1);
    send_item(ACT_CLEAR, '0, 1'b0);
    // one node takes enough full-length rods to pin its load
    for (int i = 0; i < SAT_ITEMS; i++) send_item(ACT_PLACE, '1, 1'b0);
    send_item(ACT_PLACE, 16'd2, 1'b1);
    send_item(ACT_PLACE, '1, 1'b0);
    send_item(ACT_REPORT, '0, 1'b0);
    send_item(ACT_CLEAR, '0, 1'b0);
    send_item(ACT_REPORT, '0, 1'b0);
  endtask

  task automatic test_random_items();
    logic [CFG_W-1:0] setting;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: setting = 7'd2;
        1: setting = 7'd64;
        2: setting = 7'd0;
        3: setting = 7'd127;
        4: setting = 7'd1;
        default: begin
          if ($urandom_range(0, 3) == 0) setting = CFG_W'($urandom);
          else setting = CFG_W'($urandom_range(1, 8));
        end
      endcase
      set_active_nodes(setting);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        idle_gap(pick_gap());
        send_item(pick_action(), pick_length(), ($urandom_range(0, 9) == 0));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    start           = 1'b0;
    action_i        = ACT_CLEAR;
    rod_length_i    = '0;
    rod_is_origin_i = 1'b0;
    error_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    settings_tried  = 0;
    no_gaps         = 1'b0;
    active_cfg      = 7'd1;
    empty_all_nodes();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_directed_basics();
    test_active_range();
    test_saturation();
    test_random_items();

    drain();
    repeat (100) @(posedge clk_i);
    if (outcome_q.size() != 0) report_mismatch("results never seen", 0, outcome_q.size());

    $display("sent %0d items over %0d active_nodes settings, %0d results checked",
             items_sent, settings_tried, results_checked);
    $display("covered ties, saturated load, out-of-range node counts");
    if (error_count == 0) begin
      $display("least_loaded_rod_assigner: match");
    end else begin
      $display("least_loaded_rod_assigner: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
src/llra_pkg.sv
src/llra_node_mem.sv
src/llra_cmp.sv
src/llra_seq.sv
src/least_loaded_rod_assigner.sv
sim/testbench.sv
